[rtl/core/psp_pkg.sv]
// psp_pkg: shared types, constants and tables for the polar stereographic core
// no dependencies; imported by every module under rtl/core
`default_nettype none

package psp_pkg;

    localparam int FRAC_BITS         = 16;
    localparam int CORDIC_STAGES_DEF = 20;

    localparam int LAT_W    = 24;
    localparam int LON_W    = 25;
    localparam int COORD_W  = 32;
    localparam int SPAN_W   = 31;
    localparam int CFG_IDX_W = 2;

    // angle conversion: deg * 2^(32-F) / 360 == (n * 2^(29-F) + 22.5) / 45
    localparam int FRAC_SH  = 29 - FRAC_BITS;
    localparam int BAM_LAT  = 4;
    localparam logic [26:0] RECIP_45 = 27'd95443717;
    // rounded-up reciprocal, exact for the small remainder table operands
    localparam logic [63:0] RECIP_45_UP = 64'd95443718;

    // cordic datapath
    localparam int CV_W  = 34;
    localparam int ANG_W = 34;
    localparam logic signed [CV_W-1:0]  CORDIC_GAIN  = 34'sd652032874;
    localparam logic signed [ANG_W-1:0] QUARTER_TURN = 34'sd1073741824;
    localparam logic signed [ANG_W-1:0] HALF_TURN    = 34'sd2147483648;

    localparam logic signed [31:0] KX_Q30 = 32'sd1067931032;
    localparam logic signed [31:0] KY_Q30 = 32'sd1281517231;

    // restoring divider: 32 bit magnitude shifted up by 30
    localparam int DIV_BITS = 62;
    localparam int DEN_W    = 31;

    localparam int WIN_LAT  = 5;
    localparam logic [63:0] REL_HALF = 64'd536870912;
    localparam logic [34:0] TERM_CAP = 35'h4_0000_0000;

    localparam logic signed [COORD_W-1:0] COORD_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [COORD_W-1:0] COORD_MIN = 32'sh8000_0000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_X_MIN  = 2'd0,
        CFG_X_SPAN = 2'd1,
        CFG_Y_MIN  = 2'd2,
        CFG_Y_SPAN = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic signed [CV_W-1:0]  x;
        logic signed [CV_W-1:0]  y;
        logic signed [ANG_W-1:0] a;
        logic                    flip;
    } cordic_lane_t;

    typedef struct packed {
        cordic_lane_t col;
        cordic_lane_t lon;
    } cordic_st_t;

    typedef struct packed {
        logic [DEN_W-1:0]    rem;
        logic [DIV_BITS-1:0] nq;
        logic                neg;
    } div_lane_t;

    typedef struct packed {
        logic             dvg;
        logic             sx_neg;
        logic             cy_neg;
        logic [DEN_W-1:0] den;
        div_lane_t        lx;
        div_lane_t        ly;
    } div_st_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic                      sat;
    } out_item_t;

    function automatic logic [31:0] atan_bam(input logic [4:0] i);
        logic [31:0] v;
        case (i)
            5'd0:  v = 32'd536870912;
            5'd1:  v = 32'd316933406;
            5'd2:  v = 32'd167458907;
            5'd3:  v = 32'd85004756;
            5'd4:  v = 32'd42667331;
            5'd5:  v = 32'd21354465;
            5'd6:  v = 32'd10679838;
            5'd7:  v = 32'd5340245;
            5'd8:  v = 32'd2670163;
            5'd9:  v = 32'd1335087;
            5'd10: v = 32'd667544;
            5'd11: v = 32'd333772;
            5'd12: v = 32'd166886;
            5'd13: v = 32'd83443;
            5'd14: v = 32'd41722;
            5'd15: v = 32'd20861;
            5'd16: v = 32'd10430;
            5'd17: v = 32'd5215;
            5'd18: v = 32'd2608;
            5'd19: v = 32'd1304;
            5'd20: v = 32'd652;
            5'd21: v = 32'd326;
            5'd22: v = 32'd163;
            5'd23: v = 32'd81;
            5'd24: v = 32'd41;
            5'd25: v = 32'd20;
            5'd26: v = 32'd10;
            5'd27: v = 32'd5;
            5'd28: v = 32'd3;
            5'd29: v = 32'd1;
            5'd30: v = 32'd1;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

    // low part of the binary angle for a remainder below 45
    function automatic logic [FRAC_SH-1:0] frac_tbl(input logic [5:0] b);
        logic [63:0] num;
        logic [63:0] prod;
        num  = (64'(b) << FRAC_SH) + 64'd22;
        prod = num * RECIP_45_UP;
        return prod[32 +: FRAC_SH];
    endfunction

endpackage

`default_nettype wire

[rtl/core/psp_bam_conv.sv]
// psp_bam_conv: fixed-point degrees to 32 bit binary angle, four register stages
// depends on psp_pkg (reciprocal of 45, remainder table)
`default_nettype none

module psp_bam_conv (
    input  logic                                   clk,
    input  logic                                   en,
    input  logic signed [psp_pkg::LON_W-1:0]       dq,
    output logic        [31:0]                     bam
);
    import psp_pkg::*;

    logic        neg_a_reg, neg_b_reg, neg_c_reg;
    logic [24:0] n_a_reg, n_b_reg;
    logic [51:0] prod_b_reg;
    logic [19:0] a_c_reg;
    logic [5:0]  b_c_reg;
    logic [31:0] bam_reg;

    logic [19:0] a0;
    logic [25:0] m45;
    logic [25:0] b0;
    logic [19:0] a_next;
    logic [5:0]  b_next;
    logic [32:0] r;

    always_comb
    begin
        // a0 is the quotient or one short of it
        a0  = prod_b_reg[51:32];
        m45 = 26'(a0) * 26'd45;
        b0  = 26'(n_b_reg) - m45;
        if (b0 >= 26'd45)
        begin
            a_next = a0 + 20'd1;
            b_next = 6'(b0 - 26'd45);
        end
        else
        begin
            a_next = a0;
            b_next = b0[5:0];
        end
        r = (33'(a_c_reg) << FRAC_SH) + 33'(frac_tbl(b_c_reg));
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            neg_a_reg  <= dq[LON_W-1];
            n_a_reg    <= dq[LON_W-1] ? 25'(-dq) : 25'(dq);
            neg_b_reg  <= neg_a_reg;
            n_b_reg    <= n_a_reg;
            prod_b_reg <= 52'(n_a_reg) * 52'(RECIP_45);
            neg_c_reg  <= neg_b_reg;
            a_c_reg    <= a_next;
            b_c_reg    <= b_next;
            bam_reg    <= neg_c_reg ? 32'(-r) : r[31:0];
        end
    end

    assign bam = bam_reg;

endmodule

`default_nettype wire

[rtl/core/psp_cordic_cell.sv]
// psp_cordic_cell: one rotation step for the colatitude and longitude lanes
// depends on psp_pkg (lane types, arctangent table)
`default_nettype none

module psp_cordic_cell #(
    parameter int STAGE = 0
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic                  vld_in,
    input  psp_pkg::cordic_st_t   st_in,
    output logic                  vld_out,
    output psp_pkg::cordic_st_t   st_out
);
    import psp_pkg::*;

    logic       vld_reg;
    cordic_st_t st_reg;
    cordic_st_t st_next;

    function automatic cordic_lane_t rotate(input cordic_lane_t l);
        cordic_lane_t          o;
        logic signed [CV_W-1:0] dx;
        logic signed [CV_W-1:0] dy;
        logic signed [ANG_W-1:0] at;
        dx = l.y >>> STAGE;
        dy = l.x >>> STAGE;
        at = signed'(ANG_W'(atan_bam(5'(STAGE))));
        o  = l;
        if (!l.a[ANG_W-1])
        begin
            o.x = l.x - dx;
            o.y = l.y + dy;
            o.a = l.a - at;
        end
        else
        begin
            o.x = l.x + dx;
            o.y = l.y - dy;
            o.a = l.a + at;
        end
        return o;
    endfunction

    always_comb
    begin
        st_next.col = rotate(st_in.col);
        st_next.lon = rotate(st_in.lon);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else if (en)
            vld_reg <= vld_in;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            st_reg <= st_next;
    end

    assign vld_out = vld_reg;
    assign st_out  = st_reg;

endmodule

`default_nettype wire

[rtl/core/psp_div_cell.sv]
// psp_div_cell: one restoring division step for both coordinate lanes
// depends on psp_pkg (divider state types)
`default_nettype none

module psp_div_cell (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              vld_in,
    input  psp_pkg::div_st_t  st_in,
    output logic              vld_out,
    output psp_pkg::div_st_t  st_out
);
    import psp_pkg::*;

    logic    vld_reg;
    div_st_t st_reg;
    div_st_t st_next;

    function automatic div_lane_t step(input div_lane_t l, input logic [DEN_W-1:0] den);
        div_lane_t    o;
        logic [DEN_W:0] sh;
        logic           ge;
        sh = {l.rem, l.nq[DIV_BITS-1]};
        ge = sh >= {1'b0, den};
        o  = l;
        o.rem = ge ? DEN_W'(sh - {1'b0, den}) : sh[DEN_W-1:0];
        o.nq  = {l.nq[DIV_BITS-2:0], ge};
        return o;
    endfunction

    always_comb
    begin
        st_next    = st_in;
        st_next.lx = step(st_in.lx, st_in.den);
        st_next.ly = step(st_in.ly, st_in.den);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else if (en)
            vld_reg <= vld_in;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            st_reg <= st_next;
    end

    assign vld_out = vld_reg;
    assign st_out  = st_reg;

endmodule

`default_nettype wire

[rtl/core/psp_window.sv]
// psp_window: relative position to window coordinate with clamping, five stages
// depends on psp_pkg (widths, cap and limits)
`default_nettype none

module psp_window (
    input  logic                                     clk,
    input  logic                                     en,
    input  logic                                     neg,
    input  logic        [psp_pkg::DIV_BITS-1:0]      quot,
    input  logic signed [psp_pkg::COORD_W-1:0]       mn,
    input  logic        [psp_pkg::SPAN_W-1:0]        span,
    output logic signed [psp_pkg::COORD_W-1:0]       val,
    output logic                                     sat
);
    import psp_pkg::*;

    logic [63:0] rel_reg;
    logic        rneg2_reg, rneg3_reg, rneg4_reg;
    logic [62:0] mag_reg;
    logic [61:0] ah_reg;
    logic [62:0] bl_reg;
    logic [34:0] term_reg;
    logic signed [COORD_W-1:0] val_reg;
    logic        sat_reg;

    logic [63:0] q64;
    logic [63:0] rel_next;
    logic [35:0] sum;
    logic [34:0] term_next;
    logic signed [36:0] full;

    always_comb
    begin
        q64      = {2'b00, quot};
        rel_next = neg ? (REL_HALF - q64) : (q64 + REL_HALF);

        sum = {1'b0, ah_reg[32:0], 2'b00} + 36'(bl_reg[62:30]);
        if ((ah_reg[61:33] != '0) || (sum > 36'(TERM_CAP)))
            term_next = TERM_CAP;
        else
            term_next = sum[34:0];

        full = 37'(mn) + (rneg4_reg ? -signed'({2'b00, term_reg}) : signed'({2'b00, term_reg}));
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rel_reg   <= rel_next;
            rneg2_reg <= rel_reg[63];
            mag_reg   <= rel_reg[63] ? 63'(-rel_reg) : rel_reg[62:0];
            rneg3_reg <= rneg2_reg;
            ah_reg    <= 62'(mag_reg[62:32]) * 62'(span);
            bl_reg    <= 63'(mag_reg[31:0]) * 63'(span);
            rneg4_reg <= rneg3_reg;
            term_reg  <= term_next;
            if (full > 37'(COORD_MAX))
            begin
                val_reg <= COORD_MAX;
                sat_reg <= 1'b1;
            end
            else if (full < 37'(COORD_MIN))
            begin
                val_reg <= COORD_MIN;
                sat_reg <= 1'b1;
            end
            else
            begin
                val_reg <= full[COORD_W-1:0];
                sat_reg <= 1'b0;
            end
        end
    end

    assign val = val_reg;
    assign sat = sat_reg;

endmodule

`default_nettype wire

[rtl/core/polar_stereographic_projection_core.sv]
// polar_stereographic_projection_core: southern polar stereographic map projection
// depends on psp_pkg, psp_bam_conv, psp_cordic_cell, psp_div_cell, psp_window
//
//  channel  direction  handshake              payload
//  input    in         in_valid / in_ready    lat_deg, lon_deg
//  result   out        out_valid / out_ready  map_x, map_y, saturated
//  config   in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// one point enters per cycle while the row is not stalled; the path runs through the
// cordic cell row and the 62-step restoring divider row
// every stage moves together; the row stalls only when the two-entry output
// register and skid are both full, so in_ready is a register output
// reset clears valid bits and loads the window registers (span 1.0, min 0)
`default_nettype none

module polar_stereographic_projection_core #(
    parameter int CORDIC_STAGES = psp_pkg::CORDIC_STAGES_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic signed [psp_pkg::LAT_W-1:0]       lat_deg,
    input  logic signed [psp_pkg::LON_W-1:0]       lon_deg,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic signed [psp_pkg::COORD_W-1:0]     map_x,
    output logic signed [psp_pkg::COORD_W-1:0]     map_y,
    output logic                                   saturated,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic        [psp_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic        [31:0]                     cfg_data
);
    import psp_pkg::*;

    logic adv;

    // window registers
    logic signed [COORD_W-1:0] x_min_reg, y_min_reg;
    logic [SPAN_W-1:0]         x_span_reg, y_span_reg;

    // input stage
    logic                     s0_vld_reg;
    logic signed [LON_W-1:0]  s0_colat_reg, s0_lon_reg;
    logic signed [LON_W-1:0]  lat_abs, colat_next;

    // angle conversion
    logic [BAM_LAT-1:0] bam_vld_reg;
    logic [31:0]        bam_col, bam_lon;

    // cordic row
    logic       cvld [0:CORDIC_STAGES];
    cordic_st_t cst  [0:CORDIC_STAGES];
    logic       f_vld_reg;
    cordic_st_t f_st_reg;
    cordic_lane_t fold_col, fold_lon;

    // products
    logic                t4_vld_reg, t5_vld_reg, t6_vld_reg;
    logic signed [31:0]  t4_cc_reg, t4_sc_reg, t4_cl_reg, t4_sl_reg;
    logic signed [31:0]  t5_px_reg, t5_py_reg, t5_cc_reg;
    logic                t5_dvg_reg, t5_sx_reg, t5_cy_reg;
    logic signed [31:0]  t6_qx_reg, t6_qy_reg;
    logic [DEN_W-1:0]    t6_den_reg;
    logic                t6_dvg_reg, t6_sx_reg, t6_cy_reg;
    logic signed [63:0]  px_full, py_full, qx_full, qy_full;
    cordic_lane_t        end_col, end_lon;

    // divider row
    logic    dvld [0:DIV_BITS];
    div_st_t dst  [0:DIV_BITS];

    // window stage
    logic [WIN_LAT-1:0] w_vld_reg;
    logic [2:0]         w_side_reg [0:WIN_LAT-1];
    logic signed [COORD_W-1:0] wx_val, wy_val;
    logic               wx_sat, wy_sat;
    logic [2:0]         w_side_last;
    out_item_t          pipe_item;
    logic               pipe_vld;

    // output register and skid
    logic      out_vld_reg, out_vld_next, skid_vld_reg, skid_vld_next;
    out_item_t out_item_reg, out_item_next, skid_item_reg, skid_item_next;
    logic      out_fire;

    function automatic cordic_lane_t fold(input logic [31:0] bam);
        cordic_lane_t l;
        logic signed [ANG_W-1:0] a;
        a      = ANG_W'(signed'(bam));
        l.x    = CORDIC_GAIN;
        l.y    = '0;
        l.flip = 1'b0;
        l.a    = a;
        if (a > QUARTER_TURN)
        begin
            l.a    = a - HALF_TURN;
            l.flip = 1'b1;
        end
        else if (a < -QUARTER_TURN)
        begin
            l.a    = a + HALF_TURN;
            l.flip = 1'b1;
        end
        return l;
    endfunction

    assign adv       = !skid_vld_reg;
    assign in_ready  = adv;
    assign cfg_ready = 1'b1;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_min_reg  <= '0;
            x_span_reg <= 31'd65536;
            y_min_reg  <= '0;
            y_span_reg <= 31'd65536;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_X_MIN:  x_min_reg  <= signed'(cfg_data);
                CFG_X_SPAN: x_span_reg <= cfg_data[SPAN_W-1:0];
                CFG_Y_MIN:  y_min_reg  <= signed'(cfg_data);
                CFG_Y_SPAN: y_span_reg <= cfg_data[SPAN_W-1:0];
                default:    ;
            endcase
        end
    end

    // input stage: colatitude from |lat|
    always_comb
    begin
        lat_abs    = lat_deg[LAT_W-1] ? -LON_W'(lat_deg) : LON_W'(lat_deg);
        colat_next = LON_W'(90 <<< FRAC_BITS) - lat_abs;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_vld_reg  <= 1'b0;
            bam_vld_reg <= '0;
            f_vld_reg   <= 1'b0;
            t4_vld_reg  <= 1'b0;
            t5_vld_reg  <= 1'b0;
            t6_vld_reg  <= 1'b0;
            w_vld_reg   <= '0;
        end
        else if (adv)
        begin
            s0_vld_reg  <= in_valid;
            bam_vld_reg <= {bam_vld_reg[BAM_LAT-2:0], s0_vld_reg};
            f_vld_reg   <= bam_vld_reg[BAM_LAT-1];
            t4_vld_reg  <= cvld[CORDIC_STAGES];
            t5_vld_reg  <= t4_vld_reg;
            t6_vld_reg  <= t5_vld_reg;
            w_vld_reg   <= {w_vld_reg[WIN_LAT-2:0], dvld[DIV_BITS]};
        end
    end

    psp_bam_conv u_bam_col (
        .clk (clk),
        .en  (adv),
        .dq  (s0_colat_reg),
        .bam (bam_col)
    );

    psp_bam_conv u_bam_lon (
        .clk (clk),
        .en  (adv),
        .dq  (s0_lon_reg),
        .bam (bam_lon)
    );

    always_comb
    begin
        fold_col = fold(bam_col);
        fold_lon = fold(bam_lon);
        end_col  = cst[CORDIC_STAGES].col;
        end_lon  = cst[CORDIC_STAGES].lon;
        px_full  = 64'(t4_sc_reg) * 64'(t4_sl_reg);
        py_full  = 64'(t4_sc_reg) * 64'(t4_cl_reg);
        qx_full  = 64'(t5_px_reg) * 64'(KX_Q30);
        qy_full  = 64'(t5_py_reg) * 64'(KY_Q30);
    end

    assign cvld[0] = f_vld_reg;
    assign cst[0]  = f_st_reg;

    genvar gi;
    generate
        for (gi = 0; gi < CORDIC_STAGES; gi++)
        begin : g_cordic
            psp_cordic_cell #(.STAGE(gi)) u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .en      (adv),
                .vld_in  (cvld[gi]),
                .st_in   (cst[gi]),
                .vld_out (cvld[gi+1]),
                .st_out  (cst[gi+1])
            );
        end
    endgenerate

    assign dvld[0]       = t6_vld_reg;
    assign dst[0].dvg    = t6_dvg_reg;
    assign dst[0].sx_neg = t6_sx_reg;
    assign dst[0].cy_neg = t6_cy_reg;
    assign dst[0].den    = t6_den_reg;
    assign dst[0].lx.rem = '0;
    assign dst[0].lx.neg = t6_qx_reg[31];
    assign dst[0].lx.nq  = {(t6_qx_reg[31] ? 32'(-t6_qx_reg) : 32'(t6_qx_reg)), 30'd0};
    assign dst[0].ly.rem = '0;
    assign dst[0].ly.neg = t6_qy_reg[31];
    assign dst[0].ly.nq  = {(t6_qy_reg[31] ? 32'(-t6_qy_reg) : 32'(t6_qy_reg)), 30'd0};

    generate
        for (gi = 0; gi < DIV_BITS; gi++)
        begin : g_div
            psp_div_cell u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .en      (adv),
                .vld_in  (dvld[gi]),
                .st_in   (dst[gi]),
                .vld_out (dvld[gi+1]),
                .st_out  (dst[gi+1])
            );
        end
    endgenerate

    // payload stages
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s0_colat_reg <= colat_next;
            s0_lon_reg   <= lon_deg;
            f_st_reg.col <= fold_col;
            f_st_reg.lon <= fold_lon;
            // undo the half turn fold
            t4_cc_reg <= end_col.flip ? 32'(-end_col.x) : 32'(end_col.x);
            t4_sc_reg <= end_col.flip ? 32'(-end_col.y) : 32'(end_col.y);
            t4_cl_reg <= end_lon.flip ? 32'(-end_lon.x) : 32'(end_lon.x);
            t4_sl_reg <= end_lon.flip ? 32'(-end_lon.y) : 32'(end_lon.y);
            t5_px_reg  <= px_full[61:30];
            t5_py_reg  <= py_full[61:30];
            t5_cc_reg  <= t4_cc_reg;
            t5_dvg_reg <= t4_cc_reg[31] || (t4_cc_reg == '0);
            t5_sx_reg  <= t4_sl_reg[31];
            t5_cy_reg  <= t4_cl_reg[31];
            t6_qx_reg  <= qx_full[61:30];
            t6_qy_reg  <= qy_full[61:30];
            t6_den_reg <= t5_cc_reg[DEN_W-1:0];
            t6_dvg_reg <= t5_dvg_reg;
            t6_sx_reg  <= t5_sx_reg;
            t6_cy_reg  <= t5_cy_reg;
            w_side_reg[0] <= {dst[DIV_BITS].dvg, dst[DIV_BITS].sx_neg, dst[DIV_BITS].cy_neg};
            for (int k = 1; k < WIN_LAT; k++)
                w_side_reg[k] <= w_side_reg[k-1];
        end
    end

    psp_window u_win_x (
        .clk  (clk),
        .en   (adv),
        .neg  (dst[DIV_BITS].lx.neg),
        .quot (dst[DIV_BITS].lx.nq),
        .mn   (x_min_reg),
        .span (x_span_reg),
        .val  (wx_val),
        .sat  (wx_sat)
    );

    psp_window u_win_y (
        .clk  (clk),
        .en   (adv),
        .neg  (dst[DIV_BITS].ly.neg),
        .quot (dst[DIV_BITS].ly.nq),
        .mn   (y_min_reg),
        .span (y_span_reg),
        .val  (wy_val),
        .sat  (wy_sat)
    );

    // divergence overrides the window result
    always_comb
    begin
        w_side_last = w_side_reg[WIN_LAT-1];
        pipe_vld    = w_vld_reg[WIN_LAT-1];
        if (w_side_last[2])
        begin
            pipe_item.x   = w_side_last[1] ? COORD_MIN : COORD_MAX;
            pipe_item.y   = w_side_last[0] ? COORD_MIN : COORD_MAX;
            pipe_item.sat = 1'b1;
        end
        else
        begin
            pipe_item.x   = wx_val;
            pipe_item.y   = wy_val;
            pipe_item.sat = wx_sat | wy_sat;
        end
    end

    // output register with skid
    always_comb
    begin
        out_fire       = out_vld_reg && out_ready;
        out_vld_next   = out_vld_reg;
        skid_vld_next  = skid_vld_reg;
        out_item_next  = out_item_reg;
        skid_item_next = skid_item_reg;
        if (out_fire)
        begin
            if (skid_vld_reg)
            begin
                out_item_next = skid_item_reg;
                skid_vld_next = 1'b0;
            end
            else
                out_vld_next = 1'b0;
        end
        if (adv && pipe_vld)
        begin
            if (!out_vld_next)
            begin
                out_vld_next  = 1'b1;
                out_item_next = pipe_item;
            end
            else
            begin
                skid_vld_next  = 1'b1;
                skid_item_next = pipe_item;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end
        else
        begin
            out_vld_reg  <= out_vld_next;
            skid_vld_reg <= skid_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_item_reg  <= out_item_next;
        skid_item_reg <= skid_item_next;
    end

    assign out_valid = out_vld_reg;
    assign map_x     = out_item_reg.x;
    assign map_y     = out_item_reg.y;
    assign saturated = out_item_reg.sat;

    a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_vld_reg |-> out_vld_reg)
        else $error("skid holds a transaction while the output register is empty");

    a_stall_fills_skid: assert property (@(posedge clk) disable iff (!rst_n)
        (out_vld_reg && !out_ready && pipe_vld && adv) |=> skid_vld_reg)
        else $error("finished transaction lost while the output was stalled");

    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> s0_vld_reg)
        else $error("accepted transaction did not enter the first stage");

    a_drain_keeps_out: assert property (@(posedge clk) disable iff (!rst_n)
        (out_fire && skid_vld_reg) |=> out_vld_reg)
        else $error("skid transaction not moved to the output register");

endmodule

`default_nettype wire

[dv/psp_checker.sv]
// psp_checker: predicts every projected point and compares it with the result channel
// depends on psp_pkg for port widths, result struct and register indexes
`timescale 1ns / 100ps

module psp_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    input  logic                                in_ready,
    input  logic signed [psp_pkg::LAT_W-1:0]    lat_deg,
    input  logic signed [psp_pkg::LON_W-1:0]    lon_deg,
    input  logic                                out_valid,
    input  logic                                out_ready,
    input  logic signed [psp_pkg::COORD_W-1:0]  map_x,
    input  logic signed [psp_pkg::COORD_W-1:0]  map_y,
    input  logic                                saturated,
    input  logic                                cfg_valid,
    input  logic                                cfg_ready,
    input  logic [psp_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [31:0]                         cfg_data,
    output int                                  fails,
    output int                                  pending
);
    import psp_pkg::*;

    localparam int STAGES = 20;
    localparam longint GAIN = 652032874;
    localparam longint KX = 1067931032;
    localparam longint KY = 1281517231;
    localparam longint QTURN = 64'sd1 << 30;
    localparam longint HTURN = 64'sd1 << 31;
    localparam longint unsigned CAP = 64'd1 << 34;

    longint win_x_min, win_y_min;
    longint unsigned win_x_span, win_y_span;
    out_item_t points_due[$];

    function automatic longint arctan_step(input int i);
        longint t[32];
        t = '{536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
              10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
              83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163,
              81, 41, 20, 10, 5, 3, 1, 1, 0};
        return t[i];
    endfunction

    function automatic longint to_angle(input longint dq);
        longint v;
        longint r;
        v = dq * 65536;
        r = (v + (v < 0 ? -180 : 180)) / 360;
        return longint'({32'b0, r[31:0]});
    endfunction

    function automatic void rotate(input longint ang, output longint c, output longint s);
        longint a, x, y, dx, dy;
        bit flip;
        a = ang;
        flip = 0;
        x = GAIN;
        y = 0;
        if (a >= HTURN) a -= 64'sd1 << 32;
        if (a > QTURN)
        begin
            a -= HTURN;
            flip = 1;
        end
        else if (a < -QTURN)
        begin
            a += HTURN;
            flip = 1;
        end
        for (int i = 0; i < STAGES; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (a >= 0)
            begin
                x -= dx;
                y += dy;
                a -= arctan_step(i);
            end
            else
            begin
                x += dx;
                y -= dy;
                a += arctan_step(i);
            end
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endfunction

    function automatic longint rel_position(input longint sc, input longint trig,
                                            input longint cc, input longint k);
        longint p, q;
        p = (sc * trig) >>> 30;
        q = (p * k) >>> 30;
        return (q * (64'sd1 << 30)) / cc + (64'sd1 << 29);
    endfunction

    function automatic logic [31:0] window_coord(input longint rel, input longint mn,
                                                 input longint unsigned span,
                                                 inout bit sat);
        longint unsigned mag, term;
        longint val;
        mag = rel < 0 ? longint'(-rel) : rel;
        term = (mag >> 32) * span * 4 + (((mag & 64'hFFFF_FFFF) * span) >> 30);
        if (term > CAP) term = CAP;
        val = mn + (rel < 0 ? -longint'(term) : longint'(term));
        if (val > 64'sd2147483647)
        begin
            val = 64'sd2147483647;
            sat = 1;
        end
        else if (val < -64'sd2147483648)
        begin
            val = -64'sd2147483648;
            sat = 1;
        end
        return val[31:0];
    endfunction

    function automatic out_item_t project_point(input logic signed [LAT_W-1:0] lat,
                                                input logic signed [LON_W-1:0] lon);
        longint alat, cc, sc, cl, sl;
        bit sat;
        out_item_t r;
        alat = longint'(lat);
        if (alat < 0) alat = -alat;
        sat = 0;
        rotate(to_angle((64'sd90 << 16) - alat), cc, sc);
        rotate(to_angle(longint'(lon)), cl, sl);
        if (cc <= 0)
        begin
            r.x = sl >= 0 ? COORD_MAX : COORD_MIN;
            r.y = cl >= 0 ? COORD_MAX : COORD_MIN;
            r.sat = 1'b1;
            return r;
        end
        r.x = window_coord(rel_position(sc, sl, cc, KX), win_x_min, win_x_span, sat);
        r.y = window_coord(rel_position(sc, cl, cc, KY), win_y_min, win_y_span, sat);
        r.sat = sat;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        out_item_t want;
        if (!rst_n)
        begin
            win_x_min = 0;
            win_x_span = 65536;
            win_y_min = 0;
            win_y_span = 65536;
            points_due.delete();
            fails = 0;
            pending = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_idx_t'(cfg_index))
                    CFG_X_MIN:  win_x_min = longint'(signed'(cfg_data));
                    CFG_X_SPAN: win_x_span = cfg_data[30:0];
                    CFG_Y_MIN:  win_y_min = longint'(signed'(cfg_data));
                    CFG_Y_SPAN: win_y_span = cfg_data[30:0];
                    default:    ;
                endcase
            end
            if (in_valid && in_ready)
                points_due.push_back(project_point(lat_deg, lon_deg));
            if (out_valid && out_ready)
            begin
                if (points_due.size() == 0)
                begin
                    $display("%0t: result with nothing outstanding x=%h y=%h sat=%b",
                             $time, map_x, map_y, saturated);
                    fails++;
                end
                else
                begin
                    want = points_due.pop_front();
                    if (map_x !== want.x)
                    begin
                        $display("%0t: map_x expected %h actual %h", $time, want.x, map_x);
                        fails++;
                    end
                    if (map_y !== want.y)
                    begin
                        $display("%0t: map_y expected %h actual %h", $time, want.y, map_y);
                        fails++;
                    end
                    if (saturated !== want.sat)
                    begin
                        $display("%0t: saturated expected %b actual %b",
                                 $time, want.sat, saturated);
                        fails++;
                    end
                end
            end
            pending = points_due.size();
        end
    end

endmodule

[dv/tb_polar_stereographic_projection_core.sv]
// tb_polar_stereographic_projection_core: stimulus and verdict for the projection core
// depends on psp_pkg, polar_stereographic_projection_core and psp_checker
`timescale 1ns / 100ps

module tb_polar_stereographic_projection_core;
    import psp_pkg::*;

    localparam int LAT90 = 5898240;
    localparam int LON180 = 11796480;

    logic clk = 0;
    logic rst_n = 0;
    logic in_valid = 0;
    logic in_ready;
    logic signed [LAT_W-1:0] lat_deg = '0;
    logic signed [LON_W-1:0] lon_deg = '0;
    logic out_valid;
    logic out_ready = 0;
    logic signed [COORD_W-1:0] map_x, map_y;
    logic saturated;
    logic cfg_valid = 0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [31:0] cfg_data = '0;
    int fails, pending;
    bit calm = 0;
    bit squeeze = 0;

    always #6 clk = ~clk;

    polar_stereographic_projection_core DUT (.*);

    psp_checker u_checker (.*);

    initial
    begin
        #5_000_000;
        $display("Regression FAIL");
        $finish;
    end

    // receiver: bursty back-pressure, one long hold-off once asked
    initial
    begin
        int n;
        wait (rst_n);
        forever
        begin
            @(negedge clk);
            if (squeeze)
            begin
                squeeze = 0;
                out_ready <= 0;
                repeat (300) @(negedge clk);
            end
            else if (!calm && $urandom_range(0, 3) == 0)
            begin
                n = $urandom_range(1, 8);
                out_ready <= 0;
                repeat (n - 1) @(negedge clk);
            end
            else
                out_ready <= 1;
        end
    end

    // coordinates wrap to the port widths
    task automatic send_point(input int lat, input int lon);
        if (!calm && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 0;
            repeat ($urandom_range(1, 8)) @(negedge clk);
        end
        in_valid <= 1;
        lat_deg <= LAT_W'(lat);
        lon_deg <= LON_W'(lon);
        do @(posedge clk); while (!(in_valid && in_ready));
        @(negedge clk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [31:0] data);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 0;
    endtask

    task automatic set_window(input logic [31:0] xmin, input logic [31:0] xspan,
                              input logic [31:0] ymin, input logic [31:0] yspan);
        in_valid <= 0;
        wait (pending == 0);
        repeat (110) @(negedge clk);
        write_reg(CFG_X_MIN, xmin);
        write_reg(CFG_X_SPAN, xspan);
        write_reg(CFG_Y_MIN, ymin);
        write_reg(CFG_Y_SPAN, yspan);
    endtask

    task automatic random_points(input int count);
        int lat;
        int lon;
        int pick;
        for (int i = 0; i < count; i++)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 8)
                lat = int'($urandom_range(0, 2 * LAT90)) - LAT90;
            else if (pick == 8)
                lat = int'($urandom_range(0, 4000)) - 2000;
            else
                lat = int'($urandom);
            if ($urandom_range(0, 6) != 0)
                lon = int'($urandom_range(0, 2 * LON180)) - LON180;
            else
                lon = int'($urandom);
            send_point(lat, lon);
        end
    endtask

    initial
    begin
        repeat (6) @(negedge clk);
        rst_n = 1;
        @(negedge clk);

        // poles, equator divergence, beyond-range latitude and wrapping longitude
        send_point(LAT90, 0);
        send_point(-LAT90, LON180);
        send_point(0, 0);
        send_point(0, -LON180 / 2);
        send_point(-1, LON180 / 2);
        send_point(100, -LON180);
        send_point(32'sh007F_FFFF, 32'sh00FF_FFFF);
        send_point(32'shFF80_0000, 32'shFF00_0000);
        send_point(LAT90 / 2, LON180 / 4);
        send_point(-LAT90 / 3, -LON180 / 3);
        send_point(65536, LON180 / 2 + 1);
        send_point(LAT90 - 1, LON180 - 1);
        send_point(LAT90 + 65536, 3 * LON180 / 2);

        // clamping window, then zero span
        set_window(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
        send_point(65536, LON180 / 4);
        send_point(-65536, -3 * LON180 / 4);
        send_point(5 * 65536, LON180 / 2);
        send_point(LAT90, 0);
        send_point(300, LON180 / 3);
        set_window(32'h8000_0000, 32'h0, 32'h7FFF_FFFF, 32'h0);
        send_point(LAT90 / 2, LON180 / 4);
        send_point(65536, -LON180 / 2);
        send_point(-LAT90 / 2, LON180);

        set_window(32'hFFFF_0000, 32'h0002_0000, 32'hFFFF_0000, 32'h0002_0000);
        squeeze = 1;
        random_points(280);
        set_window($urandom, $urandom, $urandom, $urandom);
        random_points(270);
        set_window(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        random_points(270);
        set_window(32'h0, 32'h0001_0000, 32'h0, 32'h0001_0000);
        random_points(270);
        set_window($urandom, $urandom_range(0, 32'h0010_0000), $urandom,
                   $urandom_range(0, 32'h0010_0000));
        random_points(270);
        calm = 1;
        random_points(270);
        in_valid <= 0;

        wait (pending == 0);
        repeat (120) @(negedge clk);
        if (fails == 0 && pending == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
